[src/sync_byte_frame_deframer_checksum_core_assert.svh]
// Assertion macros used by the checker file.
`ifndef SYNC_BYTE_FRAME_DEFRAMER_CHECKSUM_CORE_ASSERT_SVH
`define SYNC_BYTE_FRAME_DEFRAMER_CHECKSUM_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SBFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbfd same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SBFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbfd next-cycle check failed");

`endif

[src/sbfd_pkg.sv]
package sbfd_pkg;

    localparam int BYTE_W       = 8;
    localparam int SAMPLE_W     = 16;
    localparam int MAX_CHANNELS = 8;
    localparam int CHANNELS_DEF = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE = 2'd1;

    // Register reset values
    localparam logic [BYTE_W-1:0]   SYNC_BYTE_RST  = 8'h37;
    localparam logic [SAMPLE_W-1:0] FILL_VALUE_RST = 16'h0800;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [SAMPLE_W-1:0] sample_t;

    // Frame event from the tracker for the current request
    typedef struct packed {
        logic emit;
        logic ok;
    } frame_evt_t;

endpackage

[src/sbfd_byte_if.sv]
interface sbfd_byte_if;
    import sbfd_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

[src/sbfd_frame_if.sv]
interface sbfd_frame_if;
    import sbfd_pkg::*;

    logic    valid;
    logic    ready;
    sample_t channel_0;
    sample_t channel_1;
    sample_t channel_2;
    sample_t channel_3;
    sample_t channel_4;
    sample_t channel_5;
    sample_t channel_6;
    sample_t channel_7;
    logic    checksum_ok;

    modport source (
        output valid, output channel_0, output channel_1, output channel_2,
        output channel_3, output channel_4, output channel_5, output channel_6,
        output channel_7, output checksum_ok, input ready
    );
    modport sink (
        input valid, input channel_0, input channel_1, input channel_2,
        input channel_3, input channel_4, input channel_5, input channel_6,
        input channel_7, input checksum_ok, output ready
    );
endinterface

[src/sbfd_cfg_if.sv]
interface sbfd_cfg_if;
    import sbfd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SAMPLE_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/sbfd_tracker.sv]
module sbfd_tracker
    import sbfd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  byte_t      data_byte,
    input  byte_t      sync_byte,
    output frame_evt_t evt,
    output byte_t      payload [2*CHANNELS]
);

    localparam int PAYLOAD_LEN = 2 * CHANNELS;
    localparam int FRAME_LEN   = 2 * CHANNELS + 2;
    localparam int CNT_W       = $clog2(FRAME_LEN + 1);
    localparam int IDX_W       = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;

    logic             synced_reg, synced_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    byte_t            sum_reg, sum_next;
    byte_t            last_reg, last_next;
    byte_t            store_reg [PAYLOAD_LEN];
    logic             is_sync;
    logic             in_payload;

    assign is_sync    = (data_byte == sync_byte);
    assign in_payload = (cnt_reg < CNT_W'(PAYLOAD_LEN));

    // Flag a finished frame when a sync lands right after the checksum byte
    always_comb
    begin
        evt.emit = is_sync && synced_reg && (cnt_reg == CNT_W'(PAYLOAD_LEN + 1));
        evt.ok   = (sum_reg == last_reg);
    end

    // Advance position, running sum and checksum byte
    always_comb
    begin
        synced_next = synced_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        last_next   = last_reg;
        if (is_sync)
        begin
            synced_next = 1'b1;
            cnt_next    = '0;
            sum_next    = data_byte;
        end
        else if (synced_reg)
        begin
            if (in_payload)
            begin
                sum_next = sum_reg + data_byte;
            end
            else if (cnt_reg == CNT_W'(PAYLOAD_LEN))
            begin
                last_next = data_byte;
            end
            if (cnt_reg < CNT_W'(FRAME_LEN))
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg <= 1'b0;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            last_reg   <= '0;
        end
        else if (accept)
        begin
            synced_reg <= synced_next;
            cnt_reg    <= cnt_next;
            sum_reg    <= sum_next;
            last_reg   <= last_next;
        end
    end

    // Store payload bytes at their frame position
    always_ff @(posedge clk)
    begin
        if (accept && !is_sync && synced_reg && in_payload)
        begin
            store_reg[cnt_reg[IDX_W-1:0]] <= data_byte;
        end
    end

    assign payload = store_reg;

endmodule

[src/sync_byte_frame_deframer_checksum_core.sv]
// A frame result is presented in the cycle after the sync byte that closes the frame is taken.
// Throughput: one byte per cycle while bytes are not stalled; each byte updates the tracker registers.
// A result waits in the output register; bytes stall only while it is held and not taken.
// Reset (rst_n, async, active low): no frame open, sums cleared, result register empty,
// sync_byte = 0x37 and fill_value = 0x0800.
module sync_byte_frame_deframer_checksum_core
    import sbfd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    sbfd_byte_if.sink    stream,
    sbfd_frame_if.source frame,
    sbfd_cfg_if.sink     cfg
);

    byte_t      sync_byte_reg;
    sample_t    fill_reg;
    logic       accept;
    frame_evt_t evt;
    byte_t      payload [2*CHANNELS];
    sample_t    chan_next [MAX_CHANNELS];
    sample_t    chan_reg  [MAX_CHANNELS];
    logic       ok_reg;
    logic       valid_reg, valid_next;
    logic       load;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg <= SYNC_BYTE_RST;
            fill_reg      <= FILL_VALUE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SYNC_BYTE:  sync_byte_reg <= cfg.data[BYTE_W-1:0];
                REG_FILL_VALUE: fill_reg      <= cfg.data;
                default:        ;
            endcase
        end
    end

    // Take a byte whenever the result register is free or being drained
    assign stream.ready = !valid_reg || frame.ready;
    assign accept       = stream.valid && stream.ready;

    sbfd_tracker #(
        .CHANNELS (CHANNELS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (stream.data_byte),
        .sync_byte (sync_byte_reg),
        .evt       (evt),
        .payload   (payload)
    );

    // Assemble samples big-endian, or substitute fill on a bad checksum
    for (genvar k = 0; k < MAX_CHANNELS; k++)
    begin : g_chan
        if (k < CHANNELS)
        begin : g_used
            assign chan_next[k] = evt.ok ? {payload[2*k], payload[2*k+1]} : fill_reg;
        end
        else
        begin : g_unused
            assign chan_next[k] = '0;
        end
    end

    assign load       = accept && evt.emit;
    assign valid_next = load || (valid_reg && !frame.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload until a new frame loads it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chan_reg <= chan_next;
            ok_reg   <= evt.ok;
        end
    end

    assign frame.valid       = valid_reg;
    assign frame.channel_0   = chan_reg[0];
    assign frame.channel_1   = chan_reg[1];
    assign frame.channel_2   = chan_reg[2];
    assign frame.channel_3   = chan_reg[3];
    assign frame.channel_4   = chan_reg[4];
    assign frame.channel_5   = chan_reg[5];
    assign frame.channel_6   = chan_reg[6];
    assign frame.channel_7   = chan_reg[7];
    assign frame.checksum_ok = ok_reg;

endmodule

[src/sbfd_checker.sv]
`include "sync_byte_frame_deframer_checksum_core_assert.svh"

module sbfd_checker
    import sbfd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 stream_valid,
    input logic                 stream_ready,
    input logic                 frame_valid,
    input logic                 frame_ready,
    input logic                 checksum_ok,
    input sample_t              channel_0,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input sample_t              cfg_data
);

    sample_t           fill_shadow_reg;
    logic              hold_now;
    logic [SAMPLE_W:0] shown;

    // Result offered but not taken, and the visible result bits
    assign hold_now = frame_valid && !frame_ready;
    assign shown    = {checksum_ok, channel_0};

    // Track the fill value from the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_shadow_reg <= FILL_VALUE_RST;
        end
        else if (cfg_valid && cfg_ready && (cfg_index == REG_FILL_VALUE))
        begin
            fill_shadow_reg <= cfg_data;
        end
    end

    `SBFD_ASSERT_NEXT(a_result_held, hold_now, frame_valid && $stable(shown))
    `SBFD_ASSERT_NOW(a_result_from_byte, $rose(frame_valid), $past(stream_valid && stream_ready))
    `SBFD_ASSERT_NOW(a_stall_only_on_hold, !stream_ready, hold_now)
    `SBFD_ASSERT_NOW(a_fill_on_bad_sum, frame_valid && !checksum_ok, channel_0 == fill_shadow_reg)

endmodule

bind sync_byte_frame_deframer_checksum_core sbfd_checker u_sbfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .stream_valid (stream.valid),
    .stream_ready (stream.ready),
    .frame_valid  (frame.valid),
    .frame_ready  (frame.ready),
    .checksum_ok  (frame.checksum_ok),
    .channel_0    (frame.channel_0),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data)
);
